### design/mmq_pkg.sv
// Shared types and constants for the monotonic minimum queue.
// Used by the storage cells and by the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mmq_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int VALUE_BITS_DEF = 32;
	localparam int TAG_BITS_DEF   = 20;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	typedef enum logic [1:0] {
		ERR_OK         = 2'd0,
		ERR_POP_EMPTY  = 2'd1,
		ERR_PUSH_FULL  = 2'd2
	} err_code_t;

	// Update command broadcast along a row of cells.
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

`default_nettype wire

### design/mmq_fifo_cell.sv
// One entry of the queue shift row: loads a new pair at the tail position
// and takes its upper neighbour's pair when the head leaves. Uses mmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmq_fifo_cell #(
	parameter int VALUE_BITS = mmq_pkg::VALUE_BITS_DEF,
	parameter int TAG_BITS   = mmq_pkg::TAG_BITS_DEF
) (
	input  wire                               clk,
	input  mmq_pkg::cell_ctrl_t               ctrl,
	input  wire                               wr_here,
	input  wire logic signed [VALUE_BITS-1:0] din_value,
	input  wire logic        [TAG_BITS-1:0]   din_tag,
	input  wire logic signed [VALUE_BITS-1:0] nb_value,
	input  wire logic        [TAG_BITS-1:0]   nb_tag,
	output logic signed      [VALUE_BITS-1:0] value,
	output logic             [TAG_BITS-1:0]   tag
);
	import mmq_pkg::*;

	logic signed [VALUE_BITS-1:0] value_q;
	logic        [TAG_BITS-1:0]   tag_q;

	always_ff @(posedge clk) begin
		if (ctrl.push && wr_here) begin
			value_q <= din_value;
			tag_q   <= din_tag;
		end else if (ctrl.pop) begin
			value_q <= nb_value;
			tag_q   <= nb_tag;
		end
	end

	assign value = value_q;
	assign tag   = tag_q;

endmodule

`default_nettype wire

### design/mmq_mono_cell.sv
// One entry of the monotonic side row: drops itself when it exceeds a new
// value, takes the new pair at the first free slot, shifts on a head match.
// Uses mmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmq_mono_cell #(
	parameter int VALUE_BITS = mmq_pkg::VALUE_BITS_DEF,
	parameter int TAG_BITS   = mmq_pkg::TAG_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  mmq_pkg::cell_ctrl_t               ctrl,
	input  wire logic signed [VALUE_BITS-1:0] din_value,
	input  wire logic        [TAG_BITS-1:0]   din_tag,
	input  wire                               prev_keep,
	input  wire logic signed [VALUE_BITS-1:0] nb_value,
	input  wire logic        [TAG_BITS-1:0]   nb_tag,
	input  wire                               nb_occ,
	output logic signed      [VALUE_BITS-1:0] value,
	output logic             [TAG_BITS-1:0]   tag,
	output logic                              occ,
	output logic                              keep,
	output logic signed      [VALUE_BITS-1:0] nxt_value,
	output logic                              nxt_occ
);
	import mmq_pkg::*;

	logic signed [VALUE_BITS-1:0] value_q;
	logic        [TAG_BITS-1:0]   tag_q;
	logic                         occ_q;
	logic                         wr;
	logic        [TAG_BITS-1:0]   nxt_tag;

	// The row is non-decreasing, so the kept cells always form a prefix and
	// the new pair lands just above the last of them.
	assign keep = occ_q && !(value_q > din_value);
	assign wr   = prev_keep && !keep;

	always_comb begin
		nxt_value = value_q;
		nxt_tag   = tag_q;
		nxt_occ   = occ_q;
		if (ctrl.push) begin
			nxt_occ = keep || wr;
			if (wr) begin
				nxt_value = din_value;
				nxt_tag   = din_tag;
			end
		end else if (ctrl.pop) begin
			nxt_value = nb_value;
			nxt_tag   = nb_tag;
			nxt_occ   = nb_occ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= nxt_occ;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= nxt_value;
		tag_q   <= nxt_tag;
	end

	assign value = value_q;
	assign tag   = tag_q;
	assign occ   = occ_q;

endmodule

`default_nettype wire

### design/monotonic_min_queue_unit.sv
// Top level of the monotonic minimum queue: two rows of cells and the
// result buffer. Depends on mmq_pkg, mmq_fifo_cell and mmq_mono_cell.
`timescale 1ns / 1ps
`default_nettype none

// A first-in first-out queue of up to DEPTH signed values with tags that
// reports the minimum of its contents with every beat. Each input beat either
// pushes a value or pops the oldest entry, and yields exactly one result beat
// carrying the minimum (zero when empty), the occupancy and an error code;
// a pop on an empty queue or a push onto a full one changes nothing. The
// whole update happens in a single pass through two rows of DEPTH cells,
// the queue row and a monotonic side row whose cells all compare against
// the new value at once, so a new beat is accepted in every cycle unless
// the input stalls. Each result is registered in the output register, or
// in the skid entry while that is held, so one result can wait while the
// next beat is taken; input stalls only when both hold results not yet taken.
module monotonic_min_queue_unit #(
	parameter int DEPTH      = mmq_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = mmq_pkg::VALUE_BITS_DEF,
	parameter int TAG_BITS   = mmq_pkg::TAG_BITS_DEF,
	localparam int CNT_W     = $clog2(DEPTH + 1)
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire                               action,
	input  wire logic signed [VALUE_BITS-1:0] value,
	input  wire logic        [TAG_BITS-1:0]   tag,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic signed      [VALUE_BITS-1:0] front_min,
	output logic                              is_empty,
	output logic             [CNT_W-1:0]      occupancy,
	output logic             [1:0]            error_code
);
	import mmq_pkg::*;

	logic signed [VALUE_BITS-1:0] fifo_val [DEPTH];
	logic        [TAG_BITS-1:0]   fifo_tag [DEPTH];
	logic signed [VALUE_BITS-1:0] mono_val [DEPTH];
	logic        [TAG_BITS-1:0]   mono_tag [DEPTH];
	logic        [DEPTH-1:0]      mono_occ;
	logic        [DEPTH-1:0]      mono_keep;
	logic signed [VALUE_BITS-1:0] mono_nxt_val [DEPTH];
	logic        [DEPTH-1:0]      mono_nxt_occ;

	logic [CNT_W-1:0] fifo_count_q;
	logic [CNT_W-1:0] count_n;
	logic             accept;
	logic             full;
	logic             empty;
	logic             push_ok;
	logic             pop_ok;
	logic             head_match;
	err_code_t        err;
	cell_ctrl_t       fifo_ctrl;
	cell_ctrl_t       mono_ctrl;

	logic                         res_empty;
	logic signed [VALUE_BITS-1:0] res_min;

	logic                         out_valid_q;
	logic signed [VALUE_BITS-1:0] out_min_q;
	logic                         out_empty_q;
	logic        [CNT_W-1:0]      out_occ_q;
	err_code_t                    out_err_q;
	logic                         skid_valid_q;
	logic signed [VALUE_BITS-1:0] skid_min_q;
	logic                         skid_empty_q;
	logic        [CNT_W-1:0]      skid_occ_q;
	err_code_t                    skid_err_q;
	logic                         out_take;

	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign full     = (fifo_count_q == CNT_W'(DEPTH));
	assign empty    = (fifo_count_q == '0);
	assign push_ok  = accept && (action == ACT_PUSH) && !full;
	assign pop_ok   = accept && (action == ACT_POP) && !empty;

	// The side row's front leaves only when it is the very pair at the head.
	assign head_match = mono_occ[0] && (mono_val[0] == fifo_val[0])
		&& (mono_tag[0] == fifo_tag[0]);

	assign fifo_ctrl = '{push: push_ok, pop: pop_ok};
	assign mono_ctrl = '{push: push_ok, pop: pop_ok && head_match};

	always_comb begin
		count_n = fifo_count_q;
		err     = ERR_OK;
		if (accept) begin
			if (action == ACT_PUSH) begin
				if (full) begin
					err = ERR_PUSH_FULL;
				end else begin
					count_n = fifo_count_q + CNT_W'(1);
				end
			end else begin
				if (empty) begin
					err = ERR_POP_EMPTY;
				end else begin
					count_n = fifo_count_q - CNT_W'(1);
				end
			end
		end
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic signed [VALUE_BITS-1:0] f_nb_val;
			logic        [TAG_BITS-1:0]   f_nb_tag;
			logic signed [VALUE_BITS-1:0] m_nb_val;
			logic        [TAG_BITS-1:0]   m_nb_tag;
			logic                         m_nb_occ;
			logic                         m_prev_keep;

			if (i == DEPTH - 1) begin : g_last
				assign f_nb_val = fifo_val[i];
				assign f_nb_tag = fifo_tag[i];
				assign m_nb_val = mono_val[i];
				assign m_nb_tag = mono_tag[i];
				assign m_nb_occ = 1'b0;
			end else begin : g_mid
				assign f_nb_val = fifo_val[i+1];
				assign f_nb_tag = fifo_tag[i+1];
				assign m_nb_val = mono_val[i+1];
				assign m_nb_tag = mono_tag[i+1];
				assign m_nb_occ = mono_occ[i+1];
			end

			if (i == 0) begin : g_first
				assign m_prev_keep = 1'b1;
			end else begin : g_rest
				assign m_prev_keep = mono_keep[i-1];
			end

			mmq_fifo_cell #(
				.VALUE_BITS (VALUE_BITS),
				.TAG_BITS   (TAG_BITS)
			) u_fifo_cell (
				.clk       (clk),
				.ctrl      (fifo_ctrl),
				.wr_here   (fifo_count_q == CNT_W'(i)),
				.din_value (value),
				.din_tag   (tag),
				.nb_value  (f_nb_val),
				.nb_tag    (f_nb_tag),
				.value     (fifo_val[i]),
				.tag       (fifo_tag[i])
			);

			mmq_mono_cell #(
				.VALUE_BITS (VALUE_BITS),
				.TAG_BITS   (TAG_BITS)
			) u_mono_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (mono_ctrl),
				.din_value (value),
				.din_tag   (tag),
				.prev_keep (m_prev_keep),
				.nb_value  (m_nb_val),
				.nb_tag    (m_nb_tag),
				.nb_occ    (m_nb_occ),
				.value     (mono_val[i]),
				.tag       (mono_tag[i]),
				.occ       (mono_occ[i]),
				.keep      (mono_keep[i]),
				.nxt_value (mono_nxt_val[i]),
				.nxt_occ   (mono_nxt_occ[i])
			);
		end
	endgenerate

	assign res_min   = mono_nxt_occ[0] ? mono_nxt_val[0] : '0;
	assign res_empty = (count_n == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_count_q <= '0;
		end else begin
			fifo_count_q <= count_n;
		end
	end

	// Result buffer: the skid entry fills only when a result arrives while
	// the output register is held.
	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_take) begin
				out_valid_q  <= skid_valid_q || accept;
				skid_valid_q <= 1'b0;
			end else if (accept) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && skid_valid_q) begin
			out_min_q   <= skid_min_q;
			out_empty_q <= skid_empty_q;
			out_occ_q   <= skid_occ_q;
			out_err_q   <= skid_err_q;
		end else if (accept && (out_take || !out_valid_q)) begin
			out_min_q   <= res_min;
			out_empty_q <= res_empty;
			out_occ_q   <= count_n;
			out_err_q   <= err;
		end
		if (accept && out_valid_q && !out_take) begin
			skid_min_q   <= res_min;
			skid_empty_q <= res_empty;
			skid_occ_q   <= count_n;
			skid_err_q   <= err;
		end
	end

	assign out_valid  = out_valid_q;
	assign front_min  = out_min_q;
	assign is_empty   = out_empty_q;
	assign occupancy  = out_occ_q;
	assign error_code = out_err_q;

endmodule

`default_nettype wire

### tb/sv/monotonic_min_queue_checker.sv
`timescale 1ns / 1ps
// Scoreboard for monotonic_min_queue_unit. It mirrors the queue and its monotonic side row,
// predicts every result beat and compares it field by field with what the block returns.
// Depends on mmq_pkg.

module monotonic_min_queue_checker #(
	parameter int DEPTH      = mmq_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = mmq_pkg::VALUE_BITS_DEF,
	parameter int TAG_BITS   = mmq_pkg::TAG_BITS_DEF,
	parameter int CNT_W      = $clog2(DEPTH + 1)
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	input  wire                               in_stall,
	input  wire                               action,
	input  wire logic signed [VALUE_BITS-1:0] value,
	input  wire logic        [TAG_BITS-1:0]   tag,
	input  wire                               out_valid,
	input  wire                               out_stall,
	input  wire logic signed [VALUE_BITS-1:0] front_min,
	input  wire                               is_empty,
	input  wire logic        [CNT_W-1:0]      occupancy,
	input  wire logic        [1:0]            error_code,
	output int                                mismatches,
	output int                                pending
);

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] front_min;
		logic                         is_empty;
		logic [CNT_W-1:0]             occupancy;
		mmq_pkg::err_code_t           error_code;
	} queue_status_t;

	queue_status_t status_due[$];
	int fail_count = 0;

	// Mirror of the queue proper, kept as a circular store.
	logic signed [VALUE_BITS-1:0] held_value [DEPTH];
	logic        [TAG_BITS-1:0]   held_tag   [DEPTH];
	int held_head;
	int held_count;

	// Mirror of the side row: a non-decreasing run whose front is the minimum.
	logic signed [VALUE_BITS-1:0] floor_value [DEPTH];
	logic        [TAG_BITS-1:0]   floor_tag   [DEPTH];
	int floor_count;

	function automatic queue_status_t apply_beat(input logic act,
			input logic signed [VALUE_BITS-1:0] v, input logic [TAG_BITS-1:0] t);
		queue_status_t s;
		int tail;
		int i;
		s.error_code = mmq_pkg::ERR_OK;
		if (act == mmq_pkg::ACT_PUSH) begin
			if (held_count == DEPTH) begin
				s.error_code = mmq_pkg::ERR_PUSH_FULL;
			end else begin
				// Equal values stay in the row; only strictly greater ones are dropped.
				while (floor_count > 0 && floor_value[floor_count-1] > v)
					floor_count--;
				if (floor_count == DEPTH)
					floor_count--;
				floor_value[floor_count] = v;
				floor_tag[floor_count] = t;
				floor_count++;
				tail = (held_head + held_count) % DEPTH;
				held_value[tail] = v;
				held_tag[tail] = t;
				held_count++;
			end
		end else if (held_count == 0) begin
			s.error_code = mmq_pkg::ERR_POP_EMPTY;
		end else begin
			if (floor_count > 0 && floor_value[0] == held_value[held_head]
					&& floor_tag[0] == held_tag[held_head]) begin
				for (i = 1; i < floor_count; i++) begin
					floor_value[i-1] = floor_value[i];
					floor_tag[i-1] = floor_tag[i];
				end
				floor_count--;
			end
			held_head = (held_head + 1) % DEPTH;
			held_count--;
		end
		s.front_min = (floor_count > 0) ? floor_value[0] : '0;
		s.is_empty = (held_count == 0);
		s.occupancy = CNT_W'(held_count);
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		queue_status_t want;
		if (!arst_n) begin
			held_head = 0;
			held_count = 0;
			floor_count = 0;
			status_due.delete();
			pending <= 0;
			mismatches <= fail_count;
		end else begin
			if (out_valid && !out_stall) begin
				if (status_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"%t: result beat with nothing outstanding: ",
							"front_min=%0d is_empty=%0d occupancy=%0d error_code=%0d"},
							$realtime, front_min, is_empty, occupancy, error_code);
				end else begin
					want = status_due[0];
					status_due.delete(0);
					if (front_min !== want.front_min || is_empty !== want.is_empty
							|| occupancy !== want.occupancy
							|| error_code !== want.error_code) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"%t: mismatch: expected front_min=%0d ",
								"is_empty=%0d occupancy=%0d error_code=%0d, ",
								"got front_min=%0d is_empty=%0d occupancy=%0d ",
								"error_code=%0d"},
								$realtime, want.front_min, want.is_empty,
								want.occupancy, want.error_code,
								front_min, is_empty, occupancy, error_code);
					end
				end
			end
			if (in_valid && !in_stall)
				status_due.insert(status_due.size(), apply_beat(action, value, tag));
			pending <= status_due.size();
			mismatches <= fail_count;
		end
	end

endmodule

### tb/sv/monotonic_min_queue_unit_test.sv
`timescale 1ns / 1ps
// Top of the monotonic_min_queue_unit testbench: clock, reset, push and pop stimulus
// in bursts, random result stalls and the verdict. Depends on mmq_pkg, the block
// and monotonic_min_queue_checker.

module monotonic_min_queue_unit_test;

	localparam int DEPTH = mmq_pkg::DEPTH_DEF;
	localparam int VB    = mmq_pkg::VALUE_BITS_DEF;
	localparam int TB    = mmq_pkg::TAG_BITS_DEF;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int RANDOM_BEATS = 1450;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          action = mmq_pkg::ACT_PUSH;
	logic signed [VB-1:0] value = '0;
	logic        [TB-1:0] tag = '0;
	logic          out_stall = 1'b0;

	wire                  in_stall;
	wire                  out_valid;
	wire signed [VB-1:0]  front_min;
	wire                  is_empty;
	wire [CNT_W-1:0]      occupancy;
	wire [1:0]            error_code;

	int mismatches;
	int pending;
	int burst_left = 0;
	logic signed [VB-1:0] last_value = '0;

	always #1 clk = ~clk;

	monotonic_min_queue_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .value(value), .tag(tag),
		.out_valid(out_valid), .out_stall(out_stall),
		.front_min(front_min), .is_empty(is_empty),
		.occupancy(occupancy), .error_code(error_code)
	);

	monotonic_min_queue_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .value(value), .tag(tag),
		.out_valid(out_valid), .out_stall(out_stall),
		.front_min(front_min), .is_empty(is_empty),
		.occupancy(occupancy), .error_code(error_code),
		.mismatches(mismatches), .pending(pending)
	);

	// Shape 1 ramps upwards and shape 2 downwards, so the side row grows long or collapses.
	function automatic logic signed [VB-1:0] pick_value(input int shape);
		logic signed [VB-1:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: v = {1'b1, {(VB-1){1'b0}}};
					1: v = {1'b0, {(VB-1){1'b1}}};
					2: v = '0;
					default: v = '1;
				endcase
			end
			1, 2, 3: v = VB'($urandom_range(0, 16)) - VB'(8);
			default: v = VB'($urandom);
		endcase
		if (shape == 1 && $urandom_range(0, 4) != 0)
			v = last_value + VB'($urandom_range(0, 999));
		else if (shape == 2 && $urandom_range(0, 4) != 0)
			v = last_value - VB'($urandom_range(0, 999));
		last_value = v;
		return v;
	endfunction

	// Narrow tags make repeated value and tag pairs likely.
	function automatic logic [TB-1:0] pick_tag();
		return ($urandom_range(0, 1) != 0) ? TB'($urandom_range(0, 3)) : TB'($urandom);
	endfunction

	task automatic send_beat(input logic act, input logic signed [VB-1:0] v,
			input logic [TB-1:0] t);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		action <= act;
		value <= v;
		tag <= t;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		int pct;
		forever begin
			case ($urandom_range(0, 3))
				0: pct = 0;
				1: pct = 30;
				2: pct = 60;
				default: pct = 90;
			endcase
			repeat ($urandom_range(8, 80)) begin
				@(posedge clk);
				out_stall <= ($urandom_range(1, 100) <= pct);
			end
		end
	end

	initial begin
		#400000;
		$display("monotonic_min_queue_unit_test: errors");
		$finish;
	end

	initial begin
		int seg_len;
		int push_pct;
		int shape;
		int taken;
		logic act;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pop on an empty queue straight after reset.
		send_beat(mmq_pkg::ACT_POP, pick_value(0), pick_tag());
		send_beat(mmq_pkg::ACT_PUSH, {1'b1, {(VB-1){1'b0}}}, '0);
		send_beat(mmq_pkg::ACT_PUSH, {1'b0, {(VB-1){1'b1}}}, '1);
		send_beat(mmq_pkg::ACT_PUSH, '0, TB'(5));
		send_beat(mmq_pkg::ACT_PUSH, '1, TB'(6));
		repeat (5) send_beat(mmq_pkg::ACT_POP, pick_value(0), pick_tag());
		// Repeated pairs and equal values with different tags in the side row.
		send_beat(mmq_pkg::ACT_PUSH, VB'(5), TB'(1));
		send_beat(mmq_pkg::ACT_PUSH, VB'(5), TB'(1));
		send_beat(mmq_pkg::ACT_PUSH, VB'(3), TB'(2));
		send_beat(mmq_pkg::ACT_PUSH, VB'(7), TB'(3));
		send_beat(mmq_pkg::ACT_PUSH, VB'(3), TB'(2));
		send_beat(mmq_pkg::ACT_PUSH, VB'(3), TB'(9));
		repeat (6) send_beat(mmq_pkg::ACT_POP, pick_value(0), pick_tag());

		// The first segment leans hard on pushes so that the queue fills up.
		taken = 0;
		seg_len = 120;
		push_pct = 97;
		while (taken < RANDOM_BEATS) begin
			shape = $urandom_range(0, 2);
			if (seg_len > RANDOM_BEATS - taken)
				seg_len = RANDOM_BEATS - taken;
			repeat (seg_len) begin
				act = ($urandom_range(1, 100) <= push_pct) ? mmq_pkg::ACT_PUSH
					: mmq_pkg::ACT_POP;
				send_beat(act, pick_value(shape), pick_tag());
				taken++;
			end
			seg_len = $urandom_range(40, 120);
			case ($urandom_range(0, 3))
				0: push_pct = 15;
				1: push_pct = 50;
				2: push_pct = 85;
				default: push_pct = 97;
			endcase
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("monotonic_min_queue_unit_test: clean");
		else
			$display("monotonic_min_queue_unit_test: errors");
		$finish;
	end

endmodule
